// ===== src/bhe_pkg.sv =====
// ----------------------------------------------------------------------------
// bhe_pkg
// Shared types, constants and a helper function for the bath hybridization
// evaluation pipeline.
// ----------------------------------------------------------------------------
package bhe_pkg;

    // word format
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int Q30_W    = 30;
    localparam int UP_SHIFT = Q30_W - FRAC_W;

    // configuration register indexes
    localparam logic [1:0] CFG_BANDWIDTH = 2'd0;
    localparam logic [1:0] CFG_COUPLING  = 2'd1;
    localparam logic [1:0] CFG_CHEM_POT  = 2'd2;

    // reset values of the configuration registers
    localparam logic signed [DATA_W-1:0] BANDWIDTH_RST = DATA_W'(1) <<< FRAC_W;
    localparam logic signed [DATA_W-1:0] COUPLING_RST  = DATA_W'(1) <<< FRAC_W;
    localparam logic signed [DATA_W-1:0] CHEM_POT_RST  = '0;

    // phase reduction: 2*pi rounded to FRAC_W fraction bits
    localparam int X_W            = 48;
    localparam int MOD_CMP_W      = 51;
    localparam int ANG_REM_W      = 19;
    localparam logic [MOD_CMP_W-1:0] TWO_PI_FIX = MOD_CMP_W'(411775);
    localparam int MOD_STEPS      = 32;
    localparam int MOD_PER_STAGE  = 4;
    localparam int MOD_STAGES     = MOD_STEPS / MOD_PER_STAGE;

    // rotation unit
    localparam int ANG_W             = 36;
    localparam int CW                = 34;
    localparam int CORDIC_STEPS      = 20;
    localparam int CORDIC_PER_STAGE  = 2;
    localparam int CORDIC_STAGES     = CORDIC_STEPS / CORDIC_PER_STAGE;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = ANG_W'(64'd1686629713);
    localparam logic signed [ANG_W-1:0] Q30_PI      = ANG_W'(64'd3373259426);
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = ANG_W'(64'd6746518852);
    localparam logic signed [CW-1:0]    Q30_ONE     = CW'(64'd1073741824);
    localparam logic signed [CW-1:0]    CORDIC_GAIN = CW'(64'd652032874);

    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097131,   32'd1048573,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    // divider
    localparam int PROD_W       = 64;
    localparam int QUOT_W       = 32;
    localparam int DIV_W        = DATA_W + UP_SHIFT;
    localparam int REM_W        = DIV_W + 1;
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES   = QUOT_W / DIV_PER_STAGE;
    localparam int MAG_W        = 49;

    // accept to result strobe, in cycles
    localparam int LATENCY = 2 + MOD_STAGES + 1 + CORDIC_STAGES + 2 + DIV_STAGES + 1;

    typedef struct packed {
        logic [1:0]               row_index;
        logic                     col_index;
        logic signed [DATA_W-1:0] time_a;
        logic signed [DATA_W-1:0] time_b;
    } bhe_request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_real;
        logic signed [DATA_W-1:0] value_imag;
        logic                     bad_index;
    } bhe_result_t;

    // per-transaction side data that travels down the pipe
    typedef struct packed {
        logic              bad;
        logic              dt_zero;
        logic              dt_neg;
        logic              dt_pos;
        logic              row1;
        logic              col1;
        logic              ang_neg;
        logic              flip;
        logic [DATA_W-1:0] dt_mag;
        logic [DATA_W-1:0] eq_imag;
    } bhe_meta_t;

    // one lane of the restoring divider
    typedef struct packed {
        logic              ovf;
        logic              neg;
        logic [REM_W-1:0]  rem;
        logic [QUOT_W-1:0] sh;
    } bhe_div_lane_t;

    // apply sign to a magnitude and saturate to a data word
    function automatic logic [DATA_W-1:0] sat_word(input logic neg,
                                                   input logic [MAG_W-1:0] m);
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] mm;
        lim = neg ? (MAG_W'(1) << (DATA_W - 1)) : ((MAG_W'(1) << (DATA_W - 1)) - MAG_W'(1));
        mm  = (m > lim) ? lim : m;
        return neg ? (DATA_W'(0) - mm[DATA_W-1:0]) : mm[DATA_W-1:0];
    endfunction

endpackage

// ===== src/bath_hybridization_eval_unit.sv =====
// ----------------------------------------------------------------------------
// bath_hybridization_eval_unit
// Complex bath hybridization value for one orbital index pair and time pair.
// ----------------------------------------------------------------------------
// usage
//   request: raise start with a request struct; the transaction is taken at
//   the clock edge where start is high and busy is low. busy is high only in
//   the first cycle after reset, so one request is taken every cycle.
//   result: result_valid is high for exactly one cycle with the result struct;
//   there is no back-pressure, results leave in request order.
//   config: cfg_we writes cfg_data into register cfg_index (bandwidth,
//   coupling, chemical potential); write only while no request is in flight.
// timing
//   throughput is one transaction per cycle. The depth from accept to the result
//   strobe is set by the modulo-2*pi reduction (eight stages of four subtract
//   steps), the rotation unit (ten stages of two iterations) and the divider
//   (eight stages of four quotient bits).
// reset
//   clears all pipeline valid bits and loads bandwidth 1.0, coupling 1.0 and
//   chemical potential 0.0.
// ----------------------------------------------------------------------------
module bath_hybridization_eval_unit
    import bhe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bhe_request_t      request,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    output logic              result_valid,
    output bhe_result_t       result
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] bandwidth_reg, coupling_reg, chem_pot_reg;
    logic busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bandwidth_reg <= BANDWIDTH_RST;
            coupling_reg  <= COUPLING_RST;
            chem_pot_reg  <= CHEM_POT_RST;
            busy_reg      <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BANDWIDTH: bandwidth_reg <= cfg_data;
                    CFG_COUPLING:  coupling_reg  <= cfg_data;
                    CFG_CHEM_POT:  chem_pot_reg  <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    assign busy = busy_reg;

    logic accept;
    logic [DATA_W-1:0] g_mag, w_mag;

    assign accept = start && !busy_reg;
    assign g_mag  = coupling_reg[DATA_W-1] ? (DATA_W'(0) - coupling_reg) : coupling_reg;
    assign w_mag  = bandwidth_reg[DATA_W-1] ? (DATA_W'(0) - bandwidth_reg) : bandwidth_reg;

    // ------------------------------------------------------------------
    // stage 0: dt and the equal-time product
    // ------------------------------------------------------------------
    logic                   s0_valid_reg;
    logic [1:0]             s0_row_reg;
    logic                   s0_col_reg;
    logic signed [DATA_W:0] s0_dt_reg, s0_dt_next;
    logic [2*DATA_W:0]      s0_eq_prod_reg, s0_eq_prod_next;
    logic                   s0_eq_neg_reg, s0_eq_neg_next;

    always_comb
    begin
        logic signed [DATA_W:0] sum, opnd;
        logic [DATA_W:0]        opnd_mag;
        logic                   pair00, pair10;
        pair00 = (request.row_index == 2'd0) && !request.col_index;
        pair10 = (request.row_index == 2'd1) && !request.col_index;
        s0_dt_next = {request.time_a[DATA_W-1], request.time_a}
                   - {request.time_b[DATA_W-1], request.time_b};
        sum  = {bandwidth_reg[DATA_W-1], bandwidth_reg}
             + {chem_pot_reg[DATA_W-1], chem_pot_reg};
        opnd = pair00 ? sum : {bandwidth_reg[DATA_W-1], bandwidth_reg};
        opnd_mag = opnd[DATA_W] ? ((DATA_W+1)'(0) - opnd) : opnd;
        s0_eq_prod_next = g_mag * opnd_mag;
        s0_eq_neg_next  = coupling_reg[DATA_W-1] ^ opnd[DATA_W] ^ !pair10;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_row_reg     <= request.row_index;
        s0_col_reg     <= request.col_index;
        s0_dt_reg      <= s0_dt_next;
        s0_eq_prod_reg <= s0_eq_prod_next;
        s0_eq_neg_reg  <= s0_eq_neg_next;
    end

    // ------------------------------------------------------------------
    // stage 1: phase product |W|*|dt| and side data
    // ------------------------------------------------------------------
    logic           s1_valid_reg;
    logic [X_W-1:0] s1_x_reg, s1_x_next;
    bhe_meta_t      s1_meta_reg, s1_meta_next;

    always_comb
    begin
        logic [DATA_W:0]     dt_abs;
        logic [2*DATA_W-1:0] prod;
        dt_abs = s0_dt_reg[DATA_W] ? ((DATA_W+1)'(0) - s0_dt_reg) : s0_dt_reg;
        prod   = w_mag * dt_abs[DATA_W-1:0];
        s1_x_next = prod[2*DATA_W-1:FRAC_W];
        s1_meta_next.bad     = s0_row_reg[1];
        s1_meta_next.dt_zero = (s0_dt_reg == '0);
        s1_meta_next.dt_neg  = s0_dt_reg[DATA_W];
        s1_meta_next.dt_pos  = !s0_dt_reg[DATA_W] && (s0_dt_reg != '0);
        s1_meta_next.row1    = s0_row_reg[0];
        s1_meta_next.col1    = s0_col_reg;
        s1_meta_next.ang_neg = bandwidth_reg[DATA_W-1] ^ s0_dt_reg[DATA_W];
        s1_meta_next.flip    = 1'b0;
        s1_meta_next.dt_mag  = dt_abs[DATA_W-1:0];
        s1_meta_next.eq_imag = sat_word(s0_eq_neg_reg, s0_eq_prod_reg[2*DATA_W:FRAC_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg    <= s1_x_next;
        s1_meta_reg <= s1_meta_next;
    end

    // ------------------------------------------------------------------
    // modulo 2*pi reduction chain
    // ------------------------------------------------------------------
    logic           mod_v [MOD_STAGES+1];
    logic [X_W-1:0] mod_x [MOD_STAGES+1];
    bhe_meta_t      mod_m [MOD_STAGES+1];

    assign mod_v[0] = s1_valid_reg;
    assign mod_x[0] = s1_x_reg;
    assign mod_m[0] = s1_meta_reg;

    for (genvar i = 0; i < MOD_STAGES; i++)
    begin : g_mod
        bhe_mod_stage #(
            .TOP_SHIFT (MOD_STEPS - 1 - i * MOD_PER_STAGE)
        ) u_mod (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (mod_v[i]),
            .in_x      (mod_x[i]),
            .in_meta   (mod_m[i]),
            .out_valid (mod_v[i+1]),
            .out_x     (mod_x[i+1]),
            .out_meta  (mod_m[i+1])
        );
    end

    // ------------------------------------------------------------------
    // angle stage: sign, wrap into [-pi, pi], fold into [-pi/2, pi/2]
    // ------------------------------------------------------------------
    logic                 ang_valid_reg;
    logic signed [CW-1:0] ang_z_reg, ang_z_next;
    bhe_meta_t            ang_meta_reg, ang_meta_next;

    always_comb
    begin
        logic signed [ANG_W-1:0] a, a_mag;
        a_mag = signed'(ANG_W'({mod_x[MOD_STAGES][ANG_REM_W-1:0], UP_SHIFT'(0)}));
        a = mod_m[MOD_STAGES].ang_neg ? -a_mag : a_mag;
        if (a > Q30_PI)
        begin
            a = a - Q30_TWO_PI;
        end
        else if (a < -Q30_PI)
        begin
            a = a + Q30_TWO_PI;
        end
        ang_meta_next = mod_m[MOD_STAGES];
        if (a > Q30_HALF_PI)
        begin
            a = a - Q30_PI;
            ang_meta_next.flip = 1'b1;
        end
        else if (a < -Q30_HALF_PI)
        begin
            a = a + Q30_PI;
            ang_meta_next.flip = 1'b1;
        end
        ang_z_next = a[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_valid_reg <= 1'b0;
        end
        else
        begin
            ang_valid_reg <= mod_v[MOD_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        ang_z_reg    <= ang_z_next;
        ang_meta_reg <= ang_meta_next;
    end

    // ------------------------------------------------------------------
    // rotation chain for cos and sin
    // ------------------------------------------------------------------
    logic                 cv [CORDIC_STAGES+1];
    logic signed [CW-1:0] cx [CORDIC_STAGES+1];
    logic signed [CW-1:0] cy [CORDIC_STAGES+1];
    logic signed [CW-1:0] cz [CORDIC_STAGES+1];
    bhe_meta_t            cm [CORDIC_STAGES+1];

    assign cv[0] = ang_valid_reg;
    assign cx[0] = CORDIC_GAIN;
    assign cy[0] = '0;
    assign cz[0] = ang_z_reg;
    assign cm[0] = ang_meta_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        bhe_cordic_stage #(
            .FIRST (i * CORDIC_PER_STAGE)
        ) u_cordic (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[i]),
            .in_x      (cx[i]),
            .in_y      (cy[i]),
            .in_z      (cz[i]),
            .in_meta   (cm[i]),
            .out_valid (cv[i+1]),
            .out_x     (cx[i+1]),
            .out_y     (cy[i+1]),
            .out_z     (cz[i+1]),
            .out_meta  (cm[i+1])
        );
    end

    // ------------------------------------------------------------------
    // post stage: Gamma*(1 - cos) and Gamma*sin on magnitudes
    // ------------------------------------------------------------------
    logic              post_valid_reg;
    logic [PROD_W-1:0] post_pa_reg, post_pa_next;
    logic [PROD_W-1:0] post_pb_reg, post_pb_next;
    logic              post_sa_reg, post_sa_next;
    logic              post_sb_reg, post_sb_next;
    bhe_meta_t         post_meta_reg;

    always_comb
    begin
        logic signed [CW-1:0] c, s, qa, qa_abs, s_abs;
        c  = cm[CORDIC_STAGES].flip ? -cx[CORDIC_STAGES] : cx[CORDIC_STAGES];
        s  = cm[CORDIC_STAGES].flip ? -cy[CORDIC_STAGES] : cy[CORDIC_STAGES];
        qa = Q30_ONE - c;
        qa_abs = qa[CW-1] ? -qa : qa;
        s_abs  = s[CW-1] ? -s : s;
        post_pa_next = g_mag * qa_abs[DATA_W-1:0];
        post_pb_next = g_mag * s_abs[DATA_W-1:0];
        post_sa_next = coupling_reg[DATA_W-1] ^ qa[CW-1] ^ cm[CORDIC_STAGES].dt_neg;
        post_sb_next = coupling_reg[DATA_W-1] ^ s[CW-1] ^ cm[CORDIC_STAGES].dt_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_valid_reg <= 1'b0;
        end
        else
        begin
            post_valid_reg <= cv[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        post_pa_reg   <= post_pa_next;
        post_pb_reg   <= post_pb_next;
        post_sa_reg   <= post_sa_next;
        post_sb_reg   <= post_sb_next;
        post_meta_reg <= cm[CORDIC_STAGES];
    end

    // ------------------------------------------------------------------
    // divider setup: overflow check and initial remainder
    // ------------------------------------------------------------------
    logic          setup_valid_reg;
    bhe_div_lane_t setup_a_reg, setup_a_next;
    bhe_div_lane_t setup_b_reg, setup_b_next;
    bhe_meta_t     setup_meta_reg;

    always_comb
    begin
        logic [DIV_W-1:0] divisor;
        divisor = {post_meta_reg.dt_mag, UP_SHIFT'(0)};
        setup_a_next.ovf = DIV_W'(post_pa_reg[PROD_W-1:QUOT_W]) >= divisor;
        setup_a_next.neg = post_sa_reg;
        setup_a_next.rem = REM_W'(post_pa_reg[PROD_W-1:QUOT_W]);
        setup_a_next.sh  = post_pa_reg[QUOT_W-1:0];
        setup_b_next.ovf = DIV_W'(post_pb_reg[PROD_W-1:QUOT_W]) >= divisor;
        setup_b_next.neg = post_sb_reg;
        setup_b_next.rem = REM_W'(post_pb_reg[PROD_W-1:QUOT_W]);
        setup_b_next.sh  = post_pb_reg[QUOT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_valid_reg <= 1'b0;
        end
        else
        begin
            setup_valid_reg <= post_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        setup_a_reg    <= setup_a_next;
        setup_b_reg    <= setup_b_next;
        setup_meta_reg <= post_meta_reg;
    end

    // ------------------------------------------------------------------
    // divider chain
    // ------------------------------------------------------------------
    logic          dv [DIV_STAGES+1];
    bhe_div_lane_t da [DIV_STAGES+1];
    bhe_div_lane_t db [DIV_STAGES+1];
    bhe_meta_t     dm [DIV_STAGES+1];

    assign dv[0] = setup_valid_reg;
    assign da[0] = setup_a_reg;
    assign db[0] = setup_b_reg;
    assign dm[0] = setup_meta_reg;

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        bhe_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv[i]),
            .in_a      (da[i]),
            .in_b      (db[i]),
            .in_meta   (dm[i]),
            .out_valid (dv[i+1]),
            .out_a     (da[i+1]),
            .out_b     (db[i+1]),
            .out_meta  (dm[i+1])
        );
    end

    // ------------------------------------------------------------------
    // output stage: sign pattern per index pair, special cases
    // ------------------------------------------------------------------
    logic        result_valid_reg;
    bhe_result_t result_reg, result_next;

    always_comb
    begin
        logic [MAG_W-1:0] ma, mb;
        bhe_div_lane_t    la, lb;
        bhe_meta_t        m;
        la = da[DIV_STAGES];
        lb = db[DIV_STAGES];
        m  = dm[DIV_STAGES];
        ma = la.ovf ? '1 : MAG_W'(la.sh);
        mb = lb.ovf ? '1 : MAG_W'(lb.sh);
        result_next = '0;
        if (m.bad)
        begin
            result_next.bad_index = 1'b1;
        end
        else if (m.dt_zero)
        begin
            result_next.value_imag = m.eq_imag;
        end
        else
        begin
            case ({m.row1, m.col1})
                2'b00:
                begin
                    result_next.value_real = sat_word(!la.neg, ma);
                    result_next.value_imag = sat_word(lb.neg ^ m.dt_pos, mb);
                end
                2'b11:
                begin
                    if (!(m.dt_pos && (chem_pot_reg > bandwidth_reg)))
                    begin
                        result_next.value_real = sat_word(la.neg, ma);
                        result_next.value_imag = sat_word(lb.neg ^ m.dt_pos, mb);
                    end
                end
                2'b01:
                begin
                    result_next.value_real = sat_word(lb.neg, mb);
                    result_next.value_imag = sat_word(la.neg, ma);
                end
                default:
                begin
                    result_next.value_real = sat_word(!lb.neg, mb);
                    result_next.value_imag = sat_word(la.neg, ma);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= dv[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // every accepted transaction yields a result after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY result_valid)
        else $error("accepted transaction produced no result");

    // no result without a matching accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, LATENCY))
        else $error("result strobe without a transaction");

    // an invalid row index gives a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.bad_index) |->
            (result.value_real == '0 && result.value_imag == '0))
        else $error("invalid index with nonzero value");

    // equal times give a purely imaginary result
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv[DIV_STAGES] && dm[DIV_STAGES].dt_zero) |=> (result.value_real == '0))
        else $error("equal times with nonzero real part");

endmodule

// ===== src/bhe_mod_stage.sv =====
// ----------------------------------------------------------------------------
// bhe_mod_stage
// One stage of the phase reduction modulo 2*pi: a few compare and subtract
// steps against shifted copies of the modulus.
// ----------------------------------------------------------------------------
module bhe_mod_stage
    import bhe_pkg::*;
#(
    parameter int TOP_SHIFT = 31
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [X_W-1:0]  in_x,
    input  bhe_meta_t       in_meta,
    output logic            out_valid,
    output logic [X_W-1:0]  out_x,
    output bhe_meta_t       out_meta
);

    logic           valid_reg;
    logic [X_W-1:0] x_reg;
    logic [X_W-1:0] x_next;
    bhe_meta_t      meta_reg;

    // restoring reduction steps
    always_comb
    begin
        logic [MOD_CMP_W-1:0] acc;
        acc = MOD_CMP_W'(in_x);
        for (int j = 0; j < MOD_PER_STAGE; j++)
        begin
            if (acc >= (TWO_PI_FIX << (TOP_SHIFT - j)))
            begin
                acc = acc - (TWO_PI_FIX << (TOP_SHIFT - j));
            end
        end
        x_next = acc[X_W-1:0];
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        meta_reg <= in_meta;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_meta  = meta_reg;

endmodule

// ===== src/bhe_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// bhe_cordic_stage
// Two rotation-mode iterations of the cos/sin unit, registered.
// ----------------------------------------------------------------------------
module bhe_cordic_stage
    import bhe_pkg::*;
#(
    parameter int FIRST = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] in_x,
    input  logic signed [CW-1:0] in_y,
    input  logic signed [CW-1:0] in_z,
    input  bhe_meta_t            in_meta,
    output logic                 out_valid,
    output logic signed [CW-1:0] out_x,
    output logic signed [CW-1:0] out_y,
    output logic signed [CW-1:0] out_z,
    output bhe_meta_t            out_meta
);

    logic                 valid_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] x_next, y_next, z_next;
    bhe_meta_t            meta_reg;

    // rotation iterations
    always_comb
    begin
        logic signed [CW-1:0] x, y, z, dx, dy, at;
        x = in_x;
        y = in_y;
        z = in_z;
        for (int j = 0; j < CORDIC_PER_STAGE; j++)
        begin
            dx = y >>> (FIRST + j);
            dy = x >>> (FIRST + j);
            at = signed'(CW'(ATAN_TABLE[FIRST + j]));
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - at;
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + at;
            end
        end
        x_next = x;
        y_next = y;
        z_next = z;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        meta_reg <= in_meta;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_meta  = meta_reg;

endmodule

// ===== src/bhe_div_stage.sv =====
// ----------------------------------------------------------------------------
// bhe_div_stage
// A few restoring division steps for both quotient lanes, which share the
// divisor |dt| scaled up to drop the Q30 extra fraction bits.
// ----------------------------------------------------------------------------
module bhe_div_stage
    import bhe_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  bhe_div_lane_t in_a,
    input  bhe_div_lane_t in_b,
    input  bhe_meta_t     in_meta,
    output logic          out_valid,
    output bhe_div_lane_t out_a,
    output bhe_div_lane_t out_b,
    output bhe_meta_t     out_meta
);

    logic          valid_reg;
    bhe_div_lane_t a_reg, b_reg;
    bhe_div_lane_t a_next, b_next;
    bhe_meta_t     meta_reg;
    logic [REM_W-1:0] divisor;

    assign divisor = REM_W'({in_meta.dt_mag, UP_SHIFT'(0)});

    // division steps, one quotient bit each
    always_comb
    begin
        logic [REM_W-1:0] ra, rb;
        a_next = in_a;
        b_next = in_b;
        for (int j = 0; j < DIV_PER_STAGE; j++)
        begin
            ra = {a_next.rem[REM_W-2:0], a_next.sh[QUOT_W-1]};
            rb = {b_next.rem[REM_W-2:0], b_next.sh[QUOT_W-1]};
            if (ra >= divisor)
            begin
                a_next.rem = ra - divisor;
                a_next.sh  = {a_next.sh[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                a_next.rem = ra;
                a_next.sh  = {a_next.sh[QUOT_W-2:0], 1'b0};
            end
            if (rb >= divisor)
            begin
                b_next.rem = rb - divisor;
                b_next.sh  = {b_next.sh[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                b_next.rem = rb;
                b_next.sh  = {b_next.sh[QUOT_W-2:0], 1'b0};
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        meta_reg <= in_meta;
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_meta  = meta_reg;

endmodule

// ===== verif/bath_hybridization_eval_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bath_hybridization_eval_unit_test
// Self-checking bench for the bath hybridization evaluator: a queue-fed driver
// issues requests, a behavioral predictor computes each expected complex value
// and a monitor compares every result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module bath_hybridization_eval_unit_test;
    import bhe_pkg::*;

    localparam longint TWO_PI_Q16 = 411775;
    localparam longint ATAN_Q30 [20] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097131, 1048573, 524288,
        262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048
    };

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    bhe_request_t      request;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [DATA_W-1:0] cfg_data;
    logic              result_valid;
    bhe_result_t       result;

    bath_hybridization_eval_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // predictor copy of the registers
    longint bw_q16;
    longint gamma_q16;
    longint mu_q16;

    bhe_request_t pending_requests [$];
    bhe_result_t  expected_values [$];
    int           send_idle_pct;
    int           error_count;
    int           result_count;
    int           request_count;
    int           bad_count;
    int           equal_time_count;

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint sat_q16(input bit neg, input longint m);
        longint lim;
        lim = neg ? 64'sd2147483648 : 64'sd2147483647;
        if (m > lim || m < 0)
            m = lim;
        return neg ? -m : m;
    endfunction

    function automatic longint abs64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // g * q / dt on magnitudes, q in Q30
    function automatic longint scale_by_dt(input longint g, input longint q,
                                           input longint dt, input bit negate);
        bit         neg;
        logic [63:0] m;
        neg = (g < 0) ^ (q < 0) ^ (dt < 0) ^ negate;
        m = (64'(abs64(g)) * 64'(abs64(q))) / 64'(abs64(dt));
        return sat_q16(neg, longint'(m >> UP_SHIFT));
    endfunction

    // rotation in Q30 with quadrant folding
    task automatic rotate_q30(input longint a, output longint cs, output longint sn);
        bit     flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (a > 64'sd3373259426)
            a -= 64'sd6746518852;
        else if (a < -64'sd3373259426)
            a += 64'sd6746518852;
        if (a > 64'sd1686629713)
        begin
            a -= 64'sd3373259426;
            flip = 1'b1;
        end
        else if (a < -64'sd1686629713)
        begin
            a += 64'sd3373259426;
            flip = 1'b1;
        end
        z = a;
        for (int i = 0; i < 20; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ATAN_Q30[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ATAN_Q30[i];
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endtask

    task automatic predict_hybridization(input bhe_request_t rq, output bhe_result_t rs);
        longint dt;
        longint re;
        longint im;
        longint sum;
        longint am;
        longint a;
        longint c;
        longint s;
        bit     neg;
        logic [63:0] p;
        re = 0;
        im = 0;
        dt = longint'(rq.time_a) - longint'(rq.time_b);
        rs.bad_index = rq.row_index > 2'd1;
        if (rs.bad_index)
            ;
        else if (dt == 0)
        begin
            if (rq.row_index == 2'd0 && !rq.col_index)
            begin
                sum = mu_q16 + bw_q16;
                p = 64'(abs64(gamma_q16)) * 64'(abs64(sum));
                im = sat_q16((gamma_q16 < 0) ^ (sum < 0) ^ 1'b1, longint'(p >> FRAC_W));
            end
            else
            begin
                neg = (gamma_q16 < 0) ^ (bw_q16 < 0) ^
                      !(rq.row_index == 2'd1 && !rq.col_index);
                p = 64'(abs64(gamma_q16)) * 64'(abs64(bw_q16));
                im = sat_q16(neg, longint'(p >> FRAC_W));
            end
        end
        else
        begin
            p = 64'(abs64(bw_q16)) * 64'(abs64(dt));
            am = longint'((p >> FRAC_W) % 64'(TWO_PI_Q16));
            a = am <<< UP_SHIFT;
            if ((bw_q16 < 0) ^ (dt < 0))
                a = -a;
            rotate_q30(a, c, s);
            if (rq.row_index == 2'd0 && !rq.col_index)
            begin
                re = scale_by_dt(gamma_q16, 64'sd1073741824 - c, dt, 1'b1);
                im = scale_by_dt(gamma_q16, s, dt, dt > 0);
            end
            else if (rq.row_index == 2'd1 && rq.col_index)
            begin
                if (!(dt > 0 && mu_q16 > bw_q16))
                begin
                    re = scale_by_dt(gamma_q16, 64'sd1073741824 - c, dt, 1'b0);
                    im = scale_by_dt(gamma_q16, s, dt, dt > 0);
                end
            end
            else
            begin
                re = scale_by_dt(gamma_q16, s, dt, rq.row_index == 2'd1);
                im = scale_by_dt(gamma_q16, 64'sd1073741824 - c, dt, 1'b0);
            end
        end
        rs.value_real = re[DATA_W-1:0];
        rs.value_imag = im[DATA_W-1:0];
    endtask

    // driver: one transaction per accepting edge, random sender gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            bhe_result_t rs;
            if (start && !busy)
            begin
                predict_hybridization(request, rs);
                expected_values.push_back(rs);
                request_count++;
                if (rs.bad_index)
                    bad_count++;
                if (request.time_a == request.time_b)
                    equal_time_count++;
            end
            if ((start && !busy) || !start)
            begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(99, 0) >= send_idle_pct)
                begin
                    start   <= 1'b1;
                    request <= pending_requests.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: compare each result strobe with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            bhe_result_t want;
            result_count++;
            if (expected_values.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                error_count++;
            end
            else
            begin
                want = expected_values.pop_front();
                if (result.value_real !== want.value_real)
                begin
                    $display("%0t: value_real expected %h actual %h",
                             $time, want.value_real, result.value_real);
                    error_count++;
                end
                if (result.value_imag !== want.value_imag)
                begin
                    $display("%0t: value_imag expected %h actual %h",
                             $time, want.value_imag, result.value_imag);
                    error_count++;
                end
                if (result.bad_index !== want.bad_index)
                begin
                    $display("%0t: bad_index expected %b actual %b",
                             $time, want.bad_index, result.bad_index);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5, 0))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(32'h0004_0000, 0);
            3: return -$urandom_range(32'h0004_0000, 0);
            default: return $urandom();
        endcase
    endfunction

    function automatic bhe_request_t random_request();
        bhe_request_t rq;
        rq.row_index = ($urandom_range(9, 0) == 0) ? 2'($urandom_range(3, 2))
                                                    : 2'($urandom_range(1, 0));
        rq.col_index = 1'($urandom_range(1, 0));
        rq.time_a    = pick_word();
        case ($urandom_range(5, 0))
            0: rq.time_b = rq.time_a;
            1: rq.time_b = rq.time_a - 32'($urandom_range(8, 1));
            2: rq.time_b = rq.time_a + 32'($urandom_range(32'h0002_0000, 1));
            default: rq.time_b = pick_word();
        endcase
        return rq;
    endfunction

    // write a register while the pipeline is empty
    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BANDWIDTH: bw_q16    = longint'(signed'(val));
            CFG_COUPLING:  gamma_q16 = longint'(signed'(val));
            default:       mu_q16    = longint'(signed'(val));
        endcase
    endtask

    task automatic drain_pipeline();
        wait (pending_requests.size() == 0 && !start && expected_values.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            pending_requests.push_back(random_request());
    endtask

    initial
    begin
        bhe_request_t rq;
        logic [31:0] cfg_words [3];
        error_count = 0;
        result_count = 0;
        request_count = 0;
        bad_count = 0;
        equal_time_count = 0;
        send_idle_pct = 17;
        bw_q16 = 65536;
        gamma_q16 = 65536;
        mu_q16 = 0;
        cfg_we = 1'b0;
        cfg_index = CFG_BANDWIDTH;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every index pair, equal times, field extremes, bad rows
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 2; c++)
            begin
                rq.row_index = 2'(r);
                rq.col_index = 1'(c);
                rq.time_a = 32'h0001_8000;
                rq.time_b = (r == 1) ? 32'h0001_8000 : 32'hffff_0000;
                pending_requests.push_back(rq);
            end
        rq = '{row_index: 2'd0, col_index: 1'b0, time_a: 32'h7fff_ffff,
               time_b: 32'h8000_0000};
        pending_requests.push_back(rq);
        rq.time_a = 32'h8000_0000;
        rq.time_b = 32'h7fff_ffff;
        pending_requests.push_back(rq);
        rq = '{row_index: 2'd1, col_index: 1'b1, time_a: 32'h0000_0001,
               time_b: 32'h0000_0000};
        pending_requests.push_back(rq);
        rq.time_a = 32'h0000_0000;
        rq.time_b = 32'h0000_0001;
        pending_requests.push_back(rq);
        rq.time_a = 32'h0000_0000;
        rq.time_b = 32'h0000_0000;
        pending_requests.push_back(rq);
        drain_pipeline();

        // pair (1,1) with mu above W, both signs of dt, then pair (0,0) at equal times
        write_register(CFG_CHEM_POT, 32'h0002_0000);
        for (int i = 0; i < 4; i++)
        begin
            rq = '{row_index: 2'd1, col_index: 1'b1,
                   time_a: (i[0] ? 32'h0003_0000 : 32'h0001_0000),
                   time_b: 32'h0002_0000};
            pending_requests.push_back(rq);
        end
        rq.row_index = 2'd0;
        rq.col_index = 1'b0;
        rq.time_a = rq.time_b;
        pending_requests.push_back(rq);
        drain_pipeline();

        // random phases over several register settings, extremes included
        for (int ph = 0; ph < 7; ph++)
        begin
            send_idle_pct = (ph < 2) ? 17 : (ph < 4) ? 73 : 0;
            case (ph)
                0: cfg_words = '{32'h0001_0000, 32'h0001_0000, 32'h0000_0000};
                1: cfg_words = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
                2: cfg_words = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
                3: cfg_words = '{32'hfffd_0000, 32'h0000_4000, 32'hffff_0000};
                default: cfg_words = '{pick_word(), pick_word(), pick_word()};
            endcase
            write_register(CFG_BANDWIDTH, cfg_words[0]);
            write_register(CFG_COUPLING, cfg_words[1]);
            write_register(CFG_CHEM_POT, cfg_words[2]);
            queue_random(250);
            drain_pipeline();
        end

        $display("covered %0d requests (%0d bad row, %0d equal times), %0d results",
                 request_count, bad_count, equal_time_count, result_count);
        $display("register settings: reset, both extremes and random values");
        if (error_count == 0 && expected_values.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // timeout
    initial
    begin
        #(12 * 200000);
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/bhe_pkg.sv
src/bhe_mod_stage.sv
src/bhe_cordic_stage.sv
src/bhe_div_stage.sv
src/bath_hybridization_eval_unit.sv
verif/bath_hybridization_eval_unit_test.sv
